/* src/kti_pkg.sv */
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants for the keyframe track interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kti_pkg;

    // Fixed field widths.
    localparam int FRAME_W = 16;
    localparam int TIME_W  = 24;
    localparam int LANE_W  = 16;
    localparam int LANES   = 4;
    localparam int VALUE_W = LANE_W * LANES;
    localparam int ENTRY_W = FRAME_W + VALUE_W;

    // Item modes.
    localparam logic MODE_SET    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Main sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_LERP,
        S_DONE
    } state_t;

    // Interpolation unit phases.
    typedef enum logic [1:0] {
        LP_IDLE,
        LP_MUL,
        LP_DIV
    } lerp_phase_t;

    // Request from the sequencer to the interpolation unit.
    typedef struct packed {
        logic              go;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] den;
    } lerp_req_t;

endpackage

`default_nettype wire

/* src/keyframe_track_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Keyframe tracks with sorted key insertion and linear sampling.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is taken at a rising edge with start high and busy low. The
// mode, track, frame_time and in_x..in_w ports are sampled at that edge.
// Exactly one result follows: done is high for one cycle while out_x..out_w,
// status, track_count, end_frame and any_keys hold the result. The receiver
// cannot stall it; busy stays high from acceptance until done has dropped.
// All keys live in one RAM with a registered read. Searches read the keys one
// at a time through the scan and check states, an insert shifts one key at a
// time through a read and a write state, and a sample between keys adds a
// multiply and a sixteen-step division. An empty track reads no key. The next
// transaction can be taken in the cycle after the result. With 32 keys per
// track the longest transaction is a sample that reads all 32 keys and
// interpolates.
// Reset empties all tracks at once through the per-track key counts; no
// clearing pass is needed because only keys below a count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyframe_track_interpolator #(
    parameter int KEYS_PER_TRACK = 32,
    parameter int TRACKS         = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic [1:0]         track,
    input  wire logic [23:0]        frame_time,
    input  wire logic signed [15:0] in_x,
    input  wire logic signed [15:0] in_y,
    input  wire logic signed [15:0] in_z,
    input  wire logic signed [15:0] in_w,
    output logic                    done,
    output logic signed [15:0]      out_x,
    output logic signed [15:0]      out_y,
    output logic signed [15:0]      out_z,
    output logic signed [15:0]      out_w,
    output logic [1:0]              status,
    output logic [5:0]              track_count,
    output logic [15:0]             end_frame,
    output logic                    any_keys
);

    localparam int CW     = $clog2(KEYS_PER_TRACK + 1);
    localparam int TIW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int DEPTH  = TRACKS * KEYS_PER_TRACK;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FW     = kti_pkg::FRAME_W;
    localparam int TW     = kti_pkg::TIME_W;
    localparam int VW     = kti_pkg::VALUE_W;
    localparam int EW     = kti_pkg::ENTRY_W;

    kti_pkg::state_t  state_reg, state_next;
    logic             mode_reg, mode_next;
    logic [1:0]       trk_reg, trk_next;
    logic [TW-1:0]    time_reg, time_next;
    logic [VW-1:0]    val_reg, val_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [EW-1:0]    prev_reg, prev_next;
    logic [VW-1:0]    lanes_reg, lanes_next;
    kti_pkg::status_t status_reg, status_next;
    logic [CW-1:0]    count_reg [TRACKS];
    logic [CW-1:0]    count_next [TRACKS];
    logic [FW-1:0]    last_reg [TRACKS];
    logic [FW-1:0]    last_next [TRACKS];

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;

    kti_pkg::lerp_req_t lerp_req;
    logic               lerp_done;
    logic [VW-1:0]      lerp_result;

    logic [TIW-1:0] in_tidx, tidx;
    logic           in_trk_ok;
    logic [FW-1:0]  set_frame, cur_f;
    logic [TW-1:0]  cur_t, prev_t;

    // Key store: frame in the top bits, four lanes below.
    kti_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_keys (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    kti_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .a     (prev_reg[VW-1:0]),
        .b     (ram_rdata[VW-1:0]),
        .done  (lerp_done),
        .result(lerp_result)
    );

    function automatic logic [ADDR_W-1:0] addr_of(input logic [TIW-1:0] t,
                                                  input logic [CW-1:0]  i);
        addr_of = ADDR_W'(ADDR_W'(t) * ADDR_W'(KEYS_PER_TRACK)) + ADDR_W'(i);
    endfunction

    assign in_tidx   = track[TIW-1:0];
    assign tidx      = trk_reg[TIW-1:0];
    assign in_trk_ok = ({1'b0, track} < 3'(TRACKS));
    assign set_frame = time_reg[TW-1:8];
    assign cur_f     = ram_rdata[EW-1:VW];
    assign cur_t     = {cur_f, 8'h00};
    assign prev_t    = {prev_reg[EW-1:VW], 8'h00};

    // Sequencer: search, shift, insert and interpolate.
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        trk_next    = trk_reg;
        time_next   = time_reg;
        val_next    = val_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        lanes_next  = lanes_reg;
        status_next = status_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_of(tidx, idx_reg);
        ram_wdata   = {set_frame, val_reg};
        ram_raddr   = addr_of(tidx, idx_reg);
        lerp_req.go  = 1'b0;
        lerp_req.dt  = time_reg - prev_t;
        lerp_req.den = cur_t - prev_t;
        unique case (state_reg)
            kti_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    trk_next    = track;
                    time_next   = frame_time;
                    val_next    = {in_w, in_z, in_y, in_x};
                    lanes_next  = '0;
                    status_next = kti_pkg::ST_OK;
                    idx_next    = '0;
                    pos_next    = '0;
                    n_next      = in_trk_ok ? count_reg[in_tidx] : '0;
                    if (!in_trk_ok)
                    begin
                        status_next = (mode == kti_pkg::MODE_SAMPLE) ? kti_pkg::ST_EMPTY
                                                                     : kti_pkg::ST_FULL;
                        state_next  = kti_pkg::S_DONE;
                    end
                    else if (count_reg[in_tidx] == '0)
                    begin
                        if (mode == kti_pkg::MODE_SAMPLE)
                        begin
                            status_next = kti_pkg::ST_EMPTY;
                            state_next  = kti_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = kti_pkg::S_INSERT;
                        end
                    end
                    else
                    begin
                        state_next = kti_pkg::S_SCAN;
                    end
                end
            end
            kti_pkg::S_SCAN:
            begin
                state_next = kti_pkg::S_CHECK;
            end
            kti_pkg::S_CHECK:
            begin
                if (mode_reg == kti_pkg::MODE_SET)
                begin
                    priority if (cur_f == set_frame)
                    begin
                        ram_we     = 1'b1;
                        state_next = kti_pkg::S_DONE;
                    end
                    else if (cur_f > set_frame || idx_reg == n_reg - CW'(1))
                    begin
                        pos_next = (cur_f > set_frame) ? idx_reg : n_reg;
                        idx_next = n_reg;
                        if (n_reg >= CW'(KEYS_PER_TRACK))
                        begin
                            status_next = kti_pkg::ST_FULL;
                            state_next  = kti_pkg::S_DONE;
                        end
                        else if (cur_f > set_frame)
                        begin
                            state_next = kti_pkg::S_SHIFT_RD;
                        end
                        else
                        begin
                            state_next = kti_pkg::S_INSERT;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = kti_pkg::S_SCAN;
                    end
                end
                else
                begin
                    priority if (idx_reg == '0 && time_reg <= cur_t)
                    begin
                        lanes_next = ram_rdata[VW-1:0];
                        state_next = kti_pkg::S_DONE;
                    end
                    else if (cur_t > time_reg)
                    begin
                        lerp_req.go = 1'b1;
                        state_next  = kti_pkg::S_LERP;
                    end
                    else if (idx_reg == n_reg - CW'(1))
                    begin
                        lanes_next = ram_rdata[VW-1:0];
                        state_next = kti_pkg::S_DONE;
                    end
                    else
                    begin
                        prev_next  = ram_rdata;
                        idx_next   = idx_reg + CW'(1);
                        state_next = kti_pkg::S_SCAN;
                    end
                end
            end
            kti_pkg::S_SHIFT_RD:
            begin
                ram_raddr  = addr_of(tidx, idx_reg - CW'(1));
                state_next = kti_pkg::S_SHIFT_WR;
            end
            kti_pkg::S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - CW'(1);
                state_next = (idx_reg - CW'(1) == pos_reg) ? kti_pkg::S_INSERT
                                                           : kti_pkg::S_SHIFT_RD;
            end
            kti_pkg::S_INSERT:
            begin
                ram_we           = 1'b1;
                ram_waddr        = addr_of(tidx, pos_reg);
                count_next[tidx] = n_reg + CW'(1);
                n_next           = n_reg + CW'(1);
                if (pos_reg == n_reg)
                begin
                    last_next[tidx] = set_frame;
                end
                state_next = kti_pkg::S_DONE;
            end
            kti_pkg::S_LERP:
            begin
                if (lerp_done)
                begin
                    lanes_next = lerp_result;
                    state_next = kti_pkg::S_DONE;
                end
            end
            kti_pkg::S_DONE:
            begin
                state_next = kti_pkg::S_IDLE;
            end
            default:
            begin
                state_next = kti_pkg::S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kti_pkg::S_IDLE;
            for (int t = 0; t < TRACKS; t++)
            begin
                count_reg[t] <= '0;
                last_reg[t]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        trk_reg    <= trk_next;
        time_reg   <= time_next;
        val_reg    <= val_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        prev_reg   <= prev_next;
        lanes_reg  <= lanes_next;
        status_reg <= status_next;
    end

    // Summary over all tracks.
    always_comb
    begin
        end_frame = '0;
        any_keys  = 1'b0;
        for (int t = 0; t < TRACKS; t++)
        begin
            if (count_reg[t] != '0)
            begin
                any_keys = 1'b1;
                if (last_reg[t] > end_frame)
                begin
                    end_frame = last_reg[t];
                end
            end
        end
    end

    assign busy        = (state_reg != kti_pkg::S_IDLE);
    assign done        = (state_reg == kti_pkg::S_DONE);
    assign out_x       = lanes_reg[15:0];
    assign out_y       = lanes_reg[31:16];
    assign out_z       = lanes_reg[47:32];
    assign out_w       = lanes_reg[63:48];
    assign status      = status_reg;
    assign track_count = 6'(n_reg);

`ifndef SYNTHESIS
    // A taken transaction always leaves the idle state.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // A key is only ever inserted into a track that still has room.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kti_pkg::S_INSERT |-> n_reg < CW'(KEYS_PER_TRACK))
        else $error("key inserted into a full track");

    // A result never carries an undefined status code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == kti_pkg::ST_OK || status == kti_pkg::ST_FULL ||
                  status == kti_pkg::ST_EMPTY))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire

/* src/kti_ram.sv */
// ----------------------------------------------------------------------------
// kti_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/kti_lerp.sv */
// ----------------------------------------------------------------------------
// kti_lerp
// Four-lane linear interpolation: a multiply phase, then a 16-step
// restoring division per lane, all lanes in parallel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kti_lerp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire kti_pkg::lerp_req_t            req,
    input  wire logic [kti_pkg::VALUE_W-1:0]   a,
    input  wire logic [kti_pkg::VALUE_W-1:0]   b,
    output logic                               done,
    output logic      [kti_pkg::VALUE_W-1:0]   result
);

    localparam int LW = kti_pkg::LANE_W;
    localparam int TW = kti_pkg::TIME_W;
    localparam int NL = kti_pkg::LANES;

    kti_pkg::lerp_phase_t phase_reg, phase_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [kti_pkg::VALUE_W-1:0] a_reg, b_reg;
    logic [TW-1:0]               dt_reg, den_reg;
    logic [TW-1:0]               rem_reg [NL];
    logic [LW-1:0]               low_reg [NL];
    logic                        neg_reg [NL];

    // Control: latch the operands, multiply, then divide for sixteen steps.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            kti_pkg::LP_IDLE:
            begin
                if (req.go)
                begin
                    phase_next = kti_pkg::LP_MUL;
                end
            end
            kti_pkg::LP_MUL:
            begin
                cnt_next   = '0;
                phase_next = kti_pkg::LP_DIV;
            end
            kti_pkg::LP_DIV:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    phase_next = kti_pkg::LP_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = kti_pkg::LP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kti_pkg::LP_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath. The quotient is below the lane difference, so it fits 16 bits
    // and the top 24 product bits already lie below the divisor.
    always_ff @(posedge clk)
    begin
        if (phase_reg == kti_pkg::LP_IDLE && req.go)
        begin
            a_reg   <= a;
            b_reg   <= b;
            dt_reg  <= req.dt;
            den_reg <= req.den;
        end
        for (int l = 0; l < NL; l++)
        begin
            logic signed [LW:0]   diff;
            logic        [LW-1:0] mag;
            logic        [TW+LW-1:0] prod;
            logic        [TW:0]   trial;
            diff  = (LW+1)'($signed(b_reg[l*LW +: LW])) - (LW+1)'($signed(a_reg[l*LW +: LW]));
            mag   = diff[LW] ? LW'(-diff) : LW'(diff);
            prod  = (TW+LW)'(mag) * (TW+LW)'(dt_reg);
            trial = {rem_reg[l], low_reg[l][LW-1]};
            if (phase_reg == kti_pkg::LP_MUL)
            begin
                neg_reg[l] <= diff[LW];
                rem_reg[l] <= prod[TW+LW-1:LW];
                low_reg[l] <= prod[LW-1:0];
            end
            else if (phase_reg == kti_pkg::LP_DIV)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg[l] <= TW'(trial - {1'b0, den_reg});
                    low_reg[l] <= {low_reg[l][LW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[l] <= trial[TW-1:0];
                    low_reg[l] <= {low_reg[l][LW-2:0], 1'b0};
                end
            end
        end
    end

    // Apply the quotient with the sign of the difference.
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            result[l*LW +: LW] = neg_reg[l] ? a_reg[l*LW +: LW] - low_reg[l]
                                            : a_reg[l*LW +: LW] + low_reg[l];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* test/keyframe_track_checker.sv */
// ----------------------------------------------------------------------------
// keyframe_track_checker
// Watches the transaction and result channels of the keyframe track
// interpolator, keeps its own copy of the key tables, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyframe_track_checker #(
    parameter int KEYS_PER_TRACK = 32,
    parameter int TRACKS         = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               mode,
    input  wire logic [1:0]         track,
    input  wire logic [23:0]        frame_time,
    input  wire logic signed [15:0] in_x,
    input  wire logic signed [15:0] in_y,
    input  wire logic signed [15:0] in_z,
    input  wire logic signed [15:0] in_w,
    input  wire logic               done,
    input  wire logic signed [15:0] out_x,
    input  wire logic signed [15:0] out_y,
    input  wire logic signed [15:0] out_z,
    input  wire logic signed [15:0] out_w,
    input  wire logic [1:0]         status,
    input  wire logic [5:0]         track_count,
    input  wire logic [15:0]        end_frame,
    input  wire logic               any_keys,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic signed [15:0] x, y, z, w;
        kti_pkg::status_t   st;
        logic [5:0]         cnt;
        logic [15:0]        endf;
        logic               anyk;
    } key_result_t;

    typedef logic signed [15:0] lanes_t [4];

    logic [15:0] frames  [TRACKS][KEYS_PER_TRACK];
    lanes_t      values  [TRACKS][KEYS_PER_TRACK];
    int          counts  [TRACKS];
    key_result_t expected_results [$];

    assign pending = expected_results.size();

    // Insert or overwrite a key; returns the resulting status.
    function automatic kti_pkg::status_t store_key(int tr, logic [15:0] f, lanes_t v);
        int n;
        int pos;
        n = counts[tr];
        for (int i = 0; i < n; i++)
            if (frames[tr][i] == f)
            begin
                values[tr][i] = v;
                return kti_pkg::ST_OK;
            end
        if (n >= KEYS_PER_TRACK)
            return kti_pkg::ST_FULL;
        pos = n;
        for (int i = n - 1; i >= 0 && frames[tr][i] > f; i--)
            pos = i;
        for (int i = n; i > pos; i--)
        begin
            frames[tr][i] = frames[tr][i-1];
            values[tr][i] = values[tr][i-1];
        end
        frames[tr][pos] = f;
        values[tr][pos] = v;
        counts[tr] = n + 1;
        return kti_pkg::ST_OK;
    endfunction

    // Sample a non-empty track at a Q16.8 time, interpolating between keys.
    function automatic lanes_t sample_track(int tr, logic [23:0] t);
        int n;
        int i;
        longint t0, t1, va, vb;
        lanes_t r;
        n = counts[tr];
        if ({8'd0, t} <= {frames[tr][0], 8'd0})
            return values[tr][0];
        if ({8'd0, t} >= {frames[tr][n-1], 8'd0})
            return values[tr][n-1];
        i = 1;
        while (i < n - 1 && {frames[tr][i], 8'd0} <= t)
            i++;
        t0 = longint'(frames[tr][i-1]) * 256;
        t1 = longint'(frames[tr][i]) * 256;
        for (int l = 0; l < 4; l++)
        begin
            va = values[tr][i-1][l];
            vb = values[tr][i][l];
            r[l] = 16'(va + ((vb - va) * (longint'(t) - t0)) / (t1 - t0));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Predict on each accepted transaction, compare on each result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        key_result_t e;
        key_result_t g;
        lanes_t v;
        lanes_t s;
        if (!rst_n)
        begin
            for (int tr = 0; tr < TRACKS; tr++)
                counts[tr] = 0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                g = '{out_x, out_y, out_z, out_w, kti_pkg::status_t'(status), track_count,
                      end_frame, any_keys};
                if (expected_results.size() == 0)
                begin
                    report_mismatch("results outstanding", 1, 0);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (g.x !== e.x) report_mismatch("out_x", g.x, e.x);
                    if (g.y !== e.y) report_mismatch("out_y", g.y, e.y);
                    if (g.z !== e.z) report_mismatch("out_z", g.z, e.z);
                    if (g.w !== e.w) report_mismatch("out_w", g.w, e.w);
                    if (g.st !== e.st) report_mismatch("status", g.st, e.st);
                    if (g.cnt !== e.cnt) report_mismatch("track_count", g.cnt, e.cnt);
                    if (g.endf !== e.endf) report_mismatch("end_frame", g.endf, e.endf);
                    if (g.anyk !== e.anyk) report_mismatch("any_keys", g.anyk, e.anyk);
                end
            end
            if (start && !busy)
            begin
                e = '0;
                v = '{in_x, in_y, in_z, in_w};
                if (track >= TRACKS)
                    e.st = (mode == kti_pkg::MODE_SAMPLE) ? kti_pkg::ST_EMPTY
                                                          : kti_pkg::ST_FULL;
                else if (mode == kti_pkg::MODE_SET)
                begin
                    e.st = store_key(track, frame_time[23:8], v);
                    e.cnt = 6'(counts[track]);
                end
                else
                begin
                    e.cnt = 6'(counts[track]);
                    if (counts[track] == 0)
                        e.st = kti_pkg::ST_EMPTY;
                    else
                    begin
                        s = sample_track(track, frame_time);
                        e.x = s[0]; e.y = s[1]; e.z = s[2]; e.w = s[3];
                    end
                end
                for (int tr = 0; tr < TRACKS; tr++)
                    if (counts[tr] > 0)
                    begin
                        e.anyk = 1'b1;
                        if (frames[tr][counts[tr]-1] > e.endf)
                            e.endf = frames[tr][counts[tr]-1];
                    end
                expected_results = {expected_results, e};
            end
        end
    end

endmodule

`default_nettype wire

/* test/keyframe_track_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_tb
// Drives set and sample transactions into the keyframe track interpolator:
// directed corner cases first, then random key building and sampling under
// several sender idling phases. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyframe_track_interpolator_tb;

    localparam int WATCHDOG_LIMIT = 5000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               mode = kti_pkg::MODE_SET;
    logic [1:0]         track = '0;
    logic [23:0]        frame_time = '0;
    logic signed [15:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
    logic               busy, done, any_keys;
    logic signed [15:0] out_x, out_y, out_z, out_w;
    logic [1:0]         status;
    logic [5:0]         track_count;
    logic [15:0]        end_frame;
    int                 fail_count, pending;
    int                 idle_pct = 0;
    int                 quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    keyframe_track_interpolator dut (.*);
    keyframe_track_checker checker_i (.*);

    // Watchdog: count cycles in which no transaction or result is accepted.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("keyframe_track_interpolator_tb NOT OK");
            $finish;
        end
    end

    // Issue one transaction and wait until it is accepted. start stays high
    // afterwards; the block is busy then, and the next call or drain() sets it.
    task automatic send_item(logic m, logic [1:0] tr, logic [23:0] t,
                             logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [15:0] w);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        mode <= m; track <= tr; frame_time <= t;
        in_x <= x; in_y <= y; in_z <= z; in_w <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_lane();
        unique case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random key set, mostly on small frames so that tracks overlap samples.
    task automatic random_set(int span);
        send_item(kti_pkg::MODE_SET, 2'($urandom),
                  {16'($urandom_range(span)), 8'($urandom)},
                  rand_lane(), rand_lane(), rand_lane(), rand_lane());
    endtask

    task automatic random_sample(int span);
        logic [23:0] t;
        t = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(span * 256 + 300));
        send_item(kti_pkg::MODE_SAMPLE, 2'($urandom), t,
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int span;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty samples, extremes, single key, fractional times.
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'd0, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SAMPLE, 2'd3, 24'hFFFFFF, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SET, 2'd0, 24'h000A80, 16'h7FFF, 16'h8000, 16'h0100,
                  16'hFF00);
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'd0, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'hFFFFFF, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SET, 2'd0, 24'h001400, 16'h8000, 16'h7FFF, 16'hFF00,
                  16'h0100);
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'h000A01, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'h000F80, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'h0013FF, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'h000A00, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SET, 2'd0, 24'h000500, 16'h1234, 16'h0000, 16'hFFFF,
                  16'h5555);
        send_item(kti_pkg::MODE_SET, 2'd0, 24'h000A00, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
        send_item(kti_pkg::MODE_SAMPLE, 2'd0, 24'h000780, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SET, 2'd1, 24'hFFFFFF, 16'hAAAA, 16'h5555, 16'hAAAA,
                  16'h5555);
        send_item(kti_pkg::MODE_SET, 2'd2, 24'h000000, 16'h5555, 16'hAAAA, 16'h5555,
                  16'hAAAA);
        send_item(kti_pkg::MODE_SAMPLE, 2'd1, 24'h000001, '0, '0, '0, '0);
        // Fill track 3 to capacity, then insert (dropped) and overwrite.
        for (int i = 0; i < 32; i++)
            send_item(kti_pkg::MODE_SET, 2'd3, {16'(i * 3 + 1), 8'h00}, 16'(i), 16'(-i),
                      16'(i * 900), 16'(-i * 900));
        send_item(kti_pkg::MODE_SET, 2'd3, 24'h000200, 16'h7FFF, '0, '0, '0);
        send_item(kti_pkg::MODE_SET, 2'd3, 24'h000400, 16'h7FFF, 16'h8000, '0, '0);
        send_item(kti_pkg::MODE_SAMPLE, 2'd3, 24'h005C80, '0, '0, '0, '0);
        send_item(kti_pkg::MODE_SAMPLE, 2'd3, 24'h001E40, '0, '0, '0, '0);

        // Pause until every result is in before the random part.
        drain();

        // Random phases with different sender idling.
        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0: idle_pct = 0;
                1: idle_pct = 64;
                2: idle_pct = 28;
                default: idle_pct = 0;
            endcase
            span = (phase == 3) ? 65535 : 60;
            for (int n = 0; n < 400; n++)
                if ($urandom_range(99) < 45)
                    random_set(span);
                else
                    random_sample(span);
        end

        drain();
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("keyframe_track_interpolator_tb OK");
        else
            $display("keyframe_track_interpolator_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
